// ----- rtl/cjtg_pkg.sv -----
// Shared constants for the cosine joint trajectory generator.
`timescale 1ns / 1ps
package cjtg_pkg;

  localparam logic [1:0] ACT_MOVE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_SYNC = 2'd2;

  localparam logic [1:0] MODE_REL = 2'd0;
  localparam logic [1:0] MODE_ABS = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TIME = 3'd1;
  localparam logic [2:0] ST_BAD_MODE = 3'd2;
  localparam logic [2:0] ST_MOVING   = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [29:0] Q30_HALF = 30'h2000_0000;
  localparam logic [32:0] PI_Q30   = 33'd3373259426;

  // Reciprocals of the sine series divisors: floor(n / k) = (n * RECIP) >> SH, exact for n < 2^30
  localparam logic [5:0] SH_72 = 6'd37;
  localparam logic [5:0] SH_42 = 6'd36;
  localparam logic [5:0] SH_20 = 6'd35;
  localparam logic [5:0] SH_6  = 6'd33;
  localparam logic [32:0] RECIP_72 = 33'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [32:0] RECIP_42 = 33'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [32:0] RECIP_20 = 33'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [32:0] RECIP_6  = 33'(((64'd1 << SH_6) + 64'd5) / 64'd6);

  localparam logic [5:0] DIV_STEPS_X = 6'd30;

endpackage

// ----- rtl/cosine_joint_trajectory_generator.sv -----
// Top level: cosine-profile reference generator for one joint.
`timescale 1ns / 1ps
// Usage
//   Input channel (item_valid / item_stall) carries action, angle, goal_ms and
//   move_mode. Output channel (result_valid / result_stall) returns one beat
//   per input beat: status, ref_angle and moving.
//   Sync, idle ticks, rejected moves, final ticks and unused actions finish in
//   the accept cycle; the registered result beat is visible in the next cycle.
//   A move beat takes goal_ms / TICK_PERIOD_MS as one reciprocal multiply on
//   the shared multiplier: its result beat is registered after S_MUL and S_STEP.
//   An interpolating tick runs one 30-step divide for count/goal, then twelve
//   passes of the single multiplier (four of them reciprocal multiplies for
//   the sine series divisors), each followed by a bookkeeping S_STEP state:
//   the result beat is registered in the last S_STEP (PH_OUT). The divider
//   produces one quotient bit per cycle.
//   item_stall stays high while a beat is in work, and while a finished
//   result is held by result_stall, so one beat is in the block at a time.
//   A stalled result beat holds its value until taken.
//   Reset (rst, synchronous) clears the reference to zero, stops motion and
//   drops any pending result beat.
module cosine_joint_trajectory_generator #(
  parameter int TICK_PERIOD_MS = 5,
  parameter int WEIGHT_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         action,
  input  logic signed [31:0] angle,
  input  logic [15:0]        goal_ms,
  input  logic [1:0]         move_mode,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         status,
  output logic signed [31:0] ref_angle,
  output logic               moving
);

  localparam int WB = WEIGHT_BITS;
  // goal_ms / TICK_PERIOD_MS = (goal_ms * GOAL_RECIP) >> GOAL_SH, exact for 16-bit goal_ms
  localparam int GOAL_SH = 23;
  localparam logic [23:0] GOAL_RECIP =
    24'(((1 << GOAL_SH) + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS);
  localparam logic [30:0] W_RND = 31'(1) << (29 - WB);
  localparam logic signed [65:0] P_RND = 66'sd1 <<< (WB - 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_STEP} state_t;
  typedef enum logic [3:0] {
    PH_GOAL, PH_X, PH_T, PH_T2, PH_A72, PH_M42, PH_A42, PH_M20,
    PH_A20, PH_M6, PH_A6, PH_S, PH_W, PH_OUT
  } phase_t;

  state_t state;
  phase_t phase;

  // Joint state
  logic               move_active;
  logic signed [31:0] current_ref;
  logic signed [31:0] start_ref;
  logic signed [31:0] target_ref;
  logic signed [32:0] ref_delta;
  logic [15:0]        tick_count;
  logic [15:0]        goal_ticks;

  // Working registers of the weight calculation
  logic [29:0] t_val;
  logic [29:0] t2_val;
  logic        flip;

  // Shared divider and multiplier
  logic [32:0]        quo;
  logic [15:0]        rem;
  logic [15:0]        divisor;
  logic [5:0]         div_cnt;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] product;

  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] rem_diff;
  assign rem_sh   = {rem, quo[32]};
  assign rem_ge   = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  logic        accept;
  logic        out_free;
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE) || !out_free;
  assign accept     = item_valid && !item_stall;

  // Decode helpers for the accept cycle
  logic signed [32:0] rel_sum;
  logic signed [31:0] tgt;
  logic [15:0]        count_inc;
  assign rel_sum   = 33'(current_ref) + 33'(angle);
  assign count_inc = tick_count + 16'd1;
  always_comb begin
    if (move_mode == cjtg_pkg::MODE_ABS) begin
      tgt = angle;
    end else if (rel_sum > 33'sh0_7FFF_FFFF) begin
      tgt = 32'sh7FFF_FFFF;
    end else if (rel_sum < -33'sh0_8000_0000) begin
      tgt = -32'sh8000_0000;
    end else begin
      tgt = rel_sum[31:0];
    end
  end

  // Quotient of a series term from its reciprocal product
  logic [29:0] recip_q;
  logic [30:0] a_new;
  always_comb begin
    case (phase)
      PH_A72:  recip_q = 30'(product[65:0] >> cjtg_pkg::SH_72);
      PH_A42:  recip_q = 30'(product[65:0] >> cjtg_pkg::SH_42);
      PH_A20:  recip_q = 30'(product[65:0] >> cjtg_pkg::SH_20);
      default: recip_q = 30'(product[65:0] >> cjtg_pkg::SH_6);
    endcase
  end
  assign a_new = cjtg_pkg::Q30_ONE - {1'b0, recip_q};

  // Helpers for the step cycle
  logic [29:0] x_val;
  logic [29:0] prod_q30;
  logic [30:0] w30;
  logic [30:0] w_sum;
  logic [WB:0] w_val;
  logic signed [65:0] p_rnd;
  logic signed [32:0] interp;
  assign x_val    = quo[29:0];
  assign prod_q30 = product[59:30];
  assign w30      = flip ? (cjtg_pkg::Q30_ONE - {1'b0, prod_q30}) : {1'b0, prod_q30};
  assign w_sum    = w30 + W_RND;
  assign w_val    = w_sum[30:30-WB];
  assign p_rnd    = product + P_RND;
  assign interp   = 33'(start_ref) + p_rnd[WB+32:WB];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_GOAL;
      move_active  <= 1'b0;
      current_ref  <= '0;
      start_ref    <= '0;
      target_ref   <= '0;
      ref_delta    <= '0;
      tick_count   <= '0;
      goal_ticks   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // Default result: reference as it stands
            result_valid <= 1'b1;
            status       <= cjtg_pkg::ST_OK;
            ref_angle    <= current_ref;
            moving       <= move_active;
            case (action)
              cjtg_pkg::ACT_MOVE: begin
                if (goal_ms == 16'd0) begin
                  status <= cjtg_pkg::ST_BAD_TIME;
                end else if (move_mode != cjtg_pkg::MODE_REL &&
                             move_mode != cjtg_pkg::MODE_ABS) begin
                  move_active <= 1'b0;
                  moving      <= 1'b0;
                  status      <= cjtg_pkg::ST_BAD_MODE;
                end else begin
                  // Latch the move; goal ticks come from the multiplier
                  result_valid <= 1'b0;
                  move_active  <= 1'b1;
                  target_ref   <= tgt;
                  start_ref    <= current_ref;
                  ref_delta    <= 33'(tgt) - 33'(current_ref);
                  tick_count   <= '0;
                  mul_a        <= 33'(goal_ms);
                  mul_b        <= 33'(GOAL_RECIP);
                  phase        <= PH_GOAL;
                  state        <= S_MUL;
                end
              end
              cjtg_pkg::ACT_TICK: begin
                status <= cjtg_pkg::ST_MOVING;
                if (move_active) begin
                  if (goal_ticks <= count_inc) begin
                    goal_ticks  <= '0;
                    tick_count  <= '0;
                    current_ref <= target_ref;
                    move_active <= 1'b0;
                    ref_angle   <= target_ref;
                    moving      <= 1'b0;
                    status      <= cjtg_pkg::ST_DONE;
                  end else begin
                    // Interpolate: start with x = count / goal in Q30
                    result_valid <= 1'b0;
                    tick_count   <= count_inc;
                    quo          <= '0;
                    rem          <= count_inc;
                    divisor      <= goal_ticks;
                    div_cnt      <= cjtg_pkg::DIV_STEPS_X;
                    phase        <= PH_X;
                    state        <= S_DIV;
                  end
                end
              end
              cjtg_pkg::ACT_SYNC: begin
                current_ref <= angle;
                move_active <= 1'b0;
                ref_angle   <= angle;
                moving      <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          rem     <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
          quo     <= {quo[31:0], rem_ge};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            state <= S_STEP;
          end
        end
        S_MUL: begin
          product <= mul_a * mul_b;
          state   <= S_STEP;
        end
        S_STEP: begin
          state <= S_MUL;
          unique case (phase)
            PH_GOAL: begin
              // Hold until the output slot is free
              if (out_free) begin
                goal_ticks   <= product[GOAL_SH+15:GOAL_SH];
                result_valid <= 1'b1;
                status       <= cjtg_pkg::ST_OK;
                ref_angle    <= current_ref;
                moving       <= 1'b1;
                state        <= S_IDLE;
              end else begin
                state <= S_STEP;
              end
            end
            PH_X: begin
              if (x_val > cjtg_pkg::Q30_HALF) begin
                flip  <= 1'b1;
                mul_a <= 33'(cjtg_pkg::Q30_ONE - {1'b0, x_val});
              end else begin
                flip  <= 1'b0;
                mul_a <= 33'(x_val);
              end
              mul_b <= cjtg_pkg::PI_Q30;
              phase <= PH_T;
            end
            PH_T: begin
              t_val <= product[60:31];
              mul_a <= 33'(product[60:31]);
              mul_b <= 33'(product[60:31]);
              phase <= PH_T2;
            end
            PH_T2: begin
              t2_val <= prod_q30;
              mul_a  <= 33'(prod_q30);
              mul_b  <= cjtg_pkg::RECIP_72;
              phase  <= PH_A72;
            end
            PH_A72, PH_A42, PH_A20: begin
              mul_a <= 33'(t2_val);
              mul_b <= 33'(a_new);
              phase <= (phase == PH_A72) ? PH_M42 :
                       (phase == PH_A42) ? PH_M20 : PH_M6;
            end
            PH_M42, PH_M20, PH_M6: begin
              mul_a <= 33'(prod_q30);
              mul_b <= (phase == PH_M42) ? cjtg_pkg::RECIP_42 :
                       (phase == PH_M20) ? cjtg_pkg::RECIP_20 : cjtg_pkg::RECIP_6;
              phase <= (phase == PH_M42) ? PH_A42 :
                       (phase == PH_M20) ? PH_A20 : PH_A6;
            end
            PH_A6: begin
              mul_a <= 33'(t_val);
              mul_b <= 33'(a_new);
              phase <= PH_S;
            end
            PH_S: begin
              // Square the sine to get the raw weight
              mul_a <= 33'(prod_q30);
              mul_b <= 33'(prod_q30);
              phase <= PH_W;
            end
            PH_W: begin
              mul_a <= ref_delta;
              mul_b <= 33'(w_val);
              phase <= PH_OUT;
            end
            PH_OUT: begin
              if (out_free) begin
                current_ref  <= interp[31:0];
                result_valid <= 1'b1;
                status       <= cjtg_pkg::ST_MOVING;
                ref_angle    <= interp[31:0];
                moving       <= 1'b1;
                state        <= S_IDLE;
              end else begin
                state <= S_STEP;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
